// ===== hw/rtl/shared_array_multi_stack_unit_defines.svh =====
// Assertion macros for the shared array multi-stack unit.
// No dependencies. The files that assert take this header by include.
`ifndef SHARED_ARRAY_MULTI_STACK_UNIT_DEFINES_SVH
`define SHARED_ARRAY_MULTI_STACK_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SAMS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SAMS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SAMS_ASSERT(lbl, clk, rst, prop, msg)
`define SAMS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== hw/rtl/sams_pkg.sv =====
// Package for the shared array multi-stack unit: field widths, status codes,
// sequencer state and pass types. No dependencies.
package sams_pkg;

   localparam int KEY_W    = 32;
   localparam int INDEX_W  = 3;
   localparam int SIZE_W   = 6;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_INVALID,
      STATUS_NO_ROOM,
      STATUS_EMPTY
   } status_type;

   typedef enum logic {
      KIND_PUSH,
      KIND_POP
   } kind_type;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_UP,
      PH_SECOND,
      PH_DOWN,
      PH_FINAL
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH_CUR,
      ST_FETCH_LIM,
      ST_FETCH_BELOW,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_COMMIT,
      ST_ADVANCE,
      ST_POP_DATA,
      ST_PUSH_WR,
      ST_RESP
   } state_type;

endpackage

// ===== hw/rtl/shared_array_multi_stack_unit.sv =====
// Top level of the shared array multi-stack unit: sequencer, bounds tables and entry store.
// Depends on sams_pkg and shared_array_multi_stack_unit_defines.svh.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_kind, req_stack_index, req_key_in
//   rsp       out        rsp_valid/rsp_stall   rsp_status, rsp_key_out, rsp_stack_size
//
// A pop fetches the stack bounds, reads the top entry and responds; a push into a stack with
// room fetches its bounds and limit, then writes. A push into a full stack runs the relocation
// passes, in which each stack is examined and each moved entry is read, then written.
// Reset is synchronous and restores the equal slices at once; the store is not cleared.
// The unit takes no request until the response has been accepted by the receiver.
`include "shared_array_multi_stack_unit_defines.svh"

module shared_array_multi_stack_unit #(
   parameter int CAPACITY   = 32,
   parameter int NUM_STACKS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [sams_pkg::INDEX_W-1:0]         req_stack_index,
   input  logic signed [sams_pkg::KEY_W-1:0]    req_key_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sams_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [sams_pkg::KEY_W-1:0]    rsp_key_out,
   output logic [sams_pkg::SIZE_W-1:0]          rsp_stack_size
);

   localparam int PW    = $clog2(CAPACITY + 1);
   localparam int AW    = $clog2(CAPACITY);
   localparam int SW    = $clog2(NUM_STACKS);
   localparam int SLICE = CAPACITY / NUM_STACKS;

   sams_pkg::state_type  state_ff, state_in;
   sams_pkg::phase_type  phase_ff, phase_in;
   sams_pkg::status_type status_ff, status_in;

   logic [SW-1:0]                cur_ff, cur_in;
   logic [SW-1:0]                k_ff, k_in;
   logic                         kind_ff, kind_in;
   logic [sams_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [PW-1:0]                ws_ff, ws_in;
   logic [PW-1:0]                we_ff, we_in;
   logic [PW-1:0]                lim_ff, lim_in;
   logic [PW-1:0]                bend_ff, bend_in;
   logic [PW-1:0]                ptr_ff, ptr_in;
   logic [sams_pkg::KEY_W-1:0]   rkey_ff, rkey_in;
   logic [sams_pkg::SIZE_W-1:0]  rsize_ff, rsize_in;

   logic [PW-1:0] start_ff [NUM_STACKS];
   logic [PW-1:0] end_ff   [NUM_STACKS];
   logic          tbl_we;
   logic [PW-1:0] tbl_start, tbl_end;

   logic [SW-1:0] sel;
   logic [PW-1:0] sel_start, sel_end;

   logic [sams_pkg::KEY_W-1:0] mem [CAPACITY];
   logic [sams_pkg::KEY_W-1:0] rd_ff;
   logic                       mem_we;
   logic [PW-1:0]              waddr_wide, raddr_wide;
   logic [sams_pkg::KEY_W-1:0] wdata;

   logic at_last, k_last, k_zero, full;

   assign sel_start = start_ff[sel];
   assign sel_end   = end_ff[sel];
   assign at_last   = (cur_ff == SW'(NUM_STACKS - 1));
   assign k_last    = (k_ff == SW'(NUM_STACKS - 1));
   assign k_zero    = (k_ff == '0);
   assign full      = (we_ff >= lim_ff);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      status_in = status_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      kind_in   = kind_ff;
      key_in    = key_ff;
      ws_in     = ws_ff;
      we_in     = we_ff;
      lim_in    = lim_ff;
      bend_in   = bend_ff;
      ptr_in    = ptr_ff;
      rkey_in   = rkey_ff;
      rsize_in  = rsize_ff;
      sel       = cur_ff;
      tbl_we    = 1'b0;
      tbl_start = ws_ff;
      tbl_end   = we_ff;
      mem_we    = 1'b0;
      waddr_wide = we_ff;
      wdata     = key_ff;
      raddr_wide = ptr_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      unique case (state_ff)
         sams_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               kind_in  = req_kind;
               key_in   = req_key_in;
               k_in     = req_stack_index[SW-1:0];
               cur_in   = req_stack_index[SW-1:0];
               phase_in = sams_pkg::PH_FIRST;
               rkey_in  = '0;
               rsize_in = '0;
               if (32'(req_stack_index) >= NUM_STACKS) begin
                  status_in = sams_pkg::STATUS_INVALID;
                  state_in  = sams_pkg::ST_RESP;
               end else begin
                  state_in = sams_pkg::ST_FETCH_CUR;
               end
            end
         end
         sams_pkg::ST_FETCH_CUR: begin
            ws_in      = sel_start;
            we_in      = sel_end;
            raddr_wide = sel_end - PW'(1);
            if (kind_ff == sams_pkg::KIND_POP) begin
               if (sel_end == sel_start) begin
                  status_in = sams_pkg::STATUS_EMPTY;
                  state_in  = sams_pkg::ST_RESP;
               end else begin
                  state_in = sams_pkg::ST_POP_DATA;
               end
            end else if (phase_ff == sams_pkg::PH_DOWN) begin
               state_in = sams_pkg::ST_FETCH_BELOW;
            end else begin
               state_in = sams_pkg::ST_FETCH_LIM;
            end
         end
         sams_pkg::ST_FETCH_LIM: begin
            if (!at_last) begin
               sel = cur_ff + SW'(1);
            end
            lim_in   = at_last ? PW'(CAPACITY) : sel_start;
            state_in = sams_pkg::ST_DECIDE;
         end
         sams_pkg::ST_FETCH_BELOW: begin
            sel      = cur_ff - SW'(1);
            bend_in  = sel_end;
            state_in = sams_pkg::ST_DECIDE;
         end
         sams_pkg::ST_DECIDE: begin
            case (phase_ff)
               sams_pkg::PH_FIRST: begin
                  if (!full) begin
                     state_in = sams_pkg::ST_PUSH_WR;
                  end else if (k_last) begin
                     phase_in = sams_pkg::PH_SECOND;
                     state_in = sams_pkg::ST_FETCH_CUR;
                  end else begin
                     phase_in = sams_pkg::PH_UP;
                     cur_in   = SW'(NUM_STACKS - 1);
                     state_in = sams_pkg::ST_FETCH_CUR;
                  end
               end
               sams_pkg::PH_UP: begin
                  if (full) begin
                     state_in = sams_pkg::ST_ADVANCE;
                  end else if (we_ff > ws_ff) begin
                     ptr_in   = we_ff;
                     state_in = sams_pkg::ST_SHIFT_RD;
                  end else begin
                     state_in = sams_pkg::ST_COMMIT;
                  end
               end
               sams_pkg::PH_DOWN: begin
                  if (bend_ff >= ws_ff) begin
                     state_in = sams_pkg::ST_ADVANCE;
                  end else if (we_ff > ws_ff) begin
                     ptr_in   = ws_ff;
                     state_in = sams_pkg::ST_SHIFT_RD;
                  end else begin
                     state_in = sams_pkg::ST_COMMIT;
                  end
               end
               default: begin
                  if (!full) begin
                     state_in = sams_pkg::ST_PUSH_WR;
                  end else if (phase_ff == sams_pkg::PH_SECOND && !k_zero) begin
                     phase_in = sams_pkg::PH_DOWN;
                     cur_in   = SW'(1);
                     state_in = sams_pkg::ST_FETCH_CUR;
                  end else begin
                     status_in = sams_pkg::STATUS_NO_ROOM;
                     rsize_in  = sams_pkg::SIZE_W'(we_ff - ws_ff);
                     state_in  = sams_pkg::ST_RESP;
                  end
               end
            endcase
         end
         sams_pkg::ST_SHIFT_RD: begin
            raddr_wide = (phase_ff == sams_pkg::PH_UP) ? ptr_ff - PW'(1) : ptr_ff;
            state_in   = sams_pkg::ST_SHIFT_WR;
         end
         sams_pkg::ST_SHIFT_WR: begin
            mem_we = 1'b1;
            wdata  = rd_ff;
            if (phase_ff == sams_pkg::PH_UP) begin
               waddr_wide = ptr_ff;
               ptr_in     = ptr_ff - PW'(1);
               state_in   = (ptr_ff - PW'(1) > ws_ff) ? sams_pkg::ST_SHIFT_RD
                                                     : sams_pkg::ST_COMMIT;
            end else begin
               waddr_wide = ptr_ff - PW'(1);
               ptr_in     = ptr_ff + PW'(1);
               state_in   = (ptr_ff + PW'(1) < we_ff) ? sams_pkg::ST_SHIFT_RD
                                                     : sams_pkg::ST_COMMIT;
            end
         end
         sams_pkg::ST_COMMIT: begin
            tbl_we = 1'b1;
            if (phase_ff == sams_pkg::PH_UP) begin
               tbl_start = ws_ff + PW'(1);
               tbl_end   = we_ff + PW'(1);
            end else begin
               tbl_start = ws_ff - PW'(1);
               tbl_end   = we_ff - PW'(1);
            end
            state_in = sams_pkg::ST_ADVANCE;
         end
         sams_pkg::ST_ADVANCE: begin
            state_in = sams_pkg::ST_FETCH_CUR;
            if (phase_ff == sams_pkg::PH_UP) begin
               if ({1'b0, cur_ff} > {1'b0, k_ff} + (SW+1)'(1)) begin
                  cur_in = cur_ff - SW'(1);
               end else begin
                  phase_in = sams_pkg::PH_SECOND;
                  cur_in   = k_ff;
               end
            end else begin
               if (cur_ff < k_ff) begin
                  cur_in = cur_ff + SW'(1);
               end else begin
                  // The final check after the downward pass rejects when still full.
                  phase_in = sams_pkg::PH_FINAL;
                  cur_in   = k_ff;
               end
            end
         end
         sams_pkg::ST_POP_DATA: begin
            tbl_we    = 1'b1;
            tbl_end   = we_ff - PW'(1);
            rkey_in   = rd_ff;
            rsize_in  = sams_pkg::SIZE_W'(we_ff - PW'(1) - ws_ff);
            status_in = sams_pkg::STATUS_OK;
            state_in  = sams_pkg::ST_RESP;
         end
         sams_pkg::ST_PUSH_WR: begin
            mem_we     = 1'b1;
            waddr_wide = we_ff;
            wdata      = key_ff;
            tbl_we     = 1'b1;
            tbl_end    = we_ff + PW'(1);
            rsize_in   = sams_pkg::SIZE_W'(we_ff + PW'(1) - ws_ff);
            status_in  = sams_pkg::STATUS_OK;
            state_in   = sams_pkg::ST_RESP;
         end
         sams_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = sams_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sams_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sams_pkg::ST_IDLE;
         phase_ff <= sams_pkg::PH_FIRST;
         for (int i = 0; i < NUM_STACKS; i++) begin
            start_ff[i] <= PW'(i * SLICE);
            end_ff[i]   <= PW'(i * SLICE);
         end
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (tbl_we) begin
            start_ff[cur_ff] <= tbl_start;
            end_ff[cur_ff]   <= tbl_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      ws_ff     <= ws_in;
      we_ff     <= we_in;
      lim_ff    <= lim_in;
      bend_ff   <= bend_in;
      ptr_ff    <= ptr_in;
      rkey_ff   <= rkey_in;
      rsize_ff  <= rsize_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr_wide[AW-1:0]] <= wdata;
      end
      rd_ff <= mem[raddr_wide[AW-1:0]];
   end

   assign rsp_status     = status_ff;
   assign rsp_key_out    = rkey_ff;
   assign rsp_stack_size = rsize_ff;

   `SAMS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")
   `SAMS_ASSERT(a_store_in_range, clock, reset, mem_we |-> (waddr_wide < PW'(CAPACITY)), "store write out of range")
   `SAMS_ASSERT(a_bounds_ordered, clock, reset, tbl_we |-> (tbl_start <= tbl_end), "stack bounds inverted")
   `SAMS_ASSERT(a_key_zero_on_fail, clock, reset, (rsp_valid && status_ff != sams_pkg::STATUS_OK) |-> (rkey_ff == '0), "key returned on failure")
   `SAMS_ASSERT(a_size_zero_invalid, clock, reset, (rsp_valid && (status_ff == sams_pkg::STATUS_INVALID || status_ff == sams_pkg::STATUS_EMPTY)) |-> (rsize_ff == '0), "size on failed access")

endmodule
